// ----- rtl/smd_pkg.sv -----
// Shared constants and types for the signed multiply-divide pipeline.
`default_nettype none

package smd_pkg;

	// Operand width taken from each 32-bit field; ports stay 32 bits wide.
	localparam int OPERAND_WIDTH = 32;
	localparam int FIELD_W       = 32;
	localparam int PROD_W        = 2 * OPERAND_WIDTH;

	// Largest positive quotient that fits in the signed operand width.
	localparam logic [PROD_W-1:0] LIM_POS = PROD_W'((64'd1 << (OPERAND_WIDTH - 1)) - 64'd1);

	// Data handed from one division cell to the next.
	typedef struct packed {
		logic                     valid;
		logic                     neg;
		logic                     dz;
		logic [OPERAND_WIDTH-1:0] den;
		logic [OPERAND_WIDTH-1:0] rem;
		logic [PROD_W-1:0]        dq;
	} cell_t;

	// One finished result.
	typedef struct packed {
		logic [FIELD_W-1:0] quotient;
		logic               divide_by_zero;
		logic               overflow;
	} res_t;

endpackage

`default_nettype wire

// ----- rtl/signed_mul_div_64.sv -----
// Input to m_axis_tvalid: front-end stages, division cells, result stage, output register.
// Throughput: one transfer per cycle while the skid stage is empty, through a chain of 2*OPERAND_WIDTH division cells,
// each resolving one quotient bit, fed by a two-stage magnitude and multiply front end.
// A result waiting at the output does not block input; a second one parks in the skid stage.
// Reset: arst_n clears all valid flags asynchronously; no other state is kept.
`default_nettype none

module signed_mul_div_64 (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        s_axis_tvalid,
	output logic             s_axis_tready,
	input  wire logic [95:0] s_axis_tdata,  // multiplicand[31:0], multiplier[63:32], divisor[95:64]
	output logic             m_axis_tvalid,
	input  wire logic        m_axis_tready,
	output logic [31:0]      m_axis_tdata,  // quotient[31:0]
	output logic [1:0]       m_axis_tuser   // divide_by_zero[0], overflow[1]
);
	import smd_pkg::*;

	localparam int NCELLS = PROD_W;

	logic  en;
	cell_t chain [NCELLS+1];
	res_t  res;

	assign s_axis_tready = en;

	smd_front u_front (
		.clk          (clk),
		.arst_n       (arst_n),
		.en           (en),
		.in_valid     (s_axis_tvalid),
		.multiplicand (s_axis_tdata[31:0]),
		.multiplier   (s_axis_tdata[63:32]),
		.divisor      (s_axis_tdata[95:64]),
		.cell_out     (chain[0])
	);

	// Row of division cells, one quotient bit each
	for (genvar i = 0; i < NCELLS; i++) begin : g_cell
		smd_div_cell u_cell (
			.clk      (clk),
			.arst_n   (arst_n),
			.en       (en),
			.cell_in  (chain[i]),
			.cell_out (chain[i+1])
		);
	end

	smd_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.cell_in   (chain[NCELLS]),
		.en        (en),
		.out_valid (m_axis_tvalid),
		.out_ready (m_axis_tready),
		.out_res   (res)
	);

	assign m_axis_tdata = res.quotient;
	assign m_axis_tuser = {res.overflow, res.divide_by_zero};

	// A zero divisor gives a zero quotient and no overflow
	a_dz_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(m_axis_tvalid && m_axis_tuser[0]) |-> (m_axis_tdata == '0 && !m_axis_tuser[1]))
		else $error("divide-by-zero result not cleared");

	// Input is only held off while the output register is occupied
	a_ready_hold: assert property (@(posedge clk) disable iff (!arst_n)
		!s_axis_tready |-> m_axis_tvalid)
		else $error("skid full with empty output register");

	// A stalled pipeline stays stalled until the output is taken
	a_stall: assert property (@(posedge clk) disable iff (!arst_n)
		(!s_axis_tready && !m_axis_tready) |=> !s_axis_tready)
		else $error("skid released without an output transfer");

endmodule

`default_nettype wire

// ----- rtl/smd_front.sv -----
// Front end: operand magnitudes, combined sign and the magnitude product.
`default_nettype none

module smd_front (
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	input  wire logic                        en,
	input  wire logic                        in_valid,
	input  wire logic [smd_pkg::FIELD_W-1:0] multiplicand,
	input  wire logic [smd_pkg::FIELD_W-1:0] multiplier,
	input  wire logic [smd_pkg::FIELD_W-1:0] divisor,
	output smd_pkg::cell_t                   cell_out
);
	import smd_pkg::*;

	logic [OPERAND_WIDTH-1:0] va, vb, vc;
	logic [OPERAND_WIDTH-1:0] ma, mb, mc;
	logic [OPERAND_WIDTH-1:0] ma_s1, mb_s1, mc_s1;
	logic                     neg_s1, dz_s1, valid_s1;
	cell_t                    cell_s2;

	// Take the low operand bits and form magnitudes
	always_comb begin
		va = multiplicand[OPERAND_WIDTH-1:0];
		vb = multiplier[OPERAND_WIDTH-1:0];
		vc = divisor[OPERAND_WIDTH-1:0];
		ma = va[OPERAND_WIDTH-1] ? (~va + 1'b1) : va;
		mb = vb[OPERAND_WIDTH-1] ? (~vb + 1'b1) : vb;
		mc = vc[OPERAND_WIDTH-1] ? (~vc + 1'b1) : vc;
	end

	// Stage 1: magnitudes, sign and zero-divisor flag
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (en) begin
			valid_s1 <= in_valid;
			ma_s1    <= ma;
			mb_s1    <= mb;
			mc_s1    <= mc;
			neg_s1   <= va[OPERAND_WIDTH-1] ^ vb[OPERAND_WIDTH-1] ^ vc[OPERAND_WIDTH-1];
			dz_s1    <= (vc == '0);
		end
	end

	// Stage 2: unsigned product, loaded as the dividend of the first cell
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cell_s2.valid <= 1'b0;
		end else if (en) begin
			cell_s2.valid <= valid_s1;
			cell_s2.neg   <= neg_s1;
			cell_s2.dz    <= dz_s1;
			cell_s2.den   <= mc_s1;
			cell_s2.rem   <= '0;
			cell_s2.dq    <= PROD_W'(ma_s1) * PROD_W'(mb_s1);
		end
	end

	assign cell_out = cell_s2;

endmodule

`default_nettype wire

// ----- rtl/smd_div_cell.sv -----
// One restoring-division cell: resolves a single quotient bit per transfer.
`default_nettype none

module smd_div_cell (
	input  wire logic     clk,
	input  wire logic     arst_n,
	input  wire logic     en,
	input  wire smd_pkg::cell_t cell_in,
	output smd_pkg::cell_t cell_out
);
	import smd_pkg::*;

	logic [OPERAND_WIDTH:0]   trial;
	logic [OPERAND_WIDTH:0]   diff;
	logic                     ge;
	logic [OPERAND_WIDTH-1:0] rem_next;
	cell_t                    cell_q;

	// Shift in the next dividend bit and try the subtraction
	always_comb begin
		trial    = {cell_in.rem, cell_in.dq[PROD_W-1]};
		diff     = trial - {1'b0, cell_in.den};
		ge       = (trial >= {1'b0, cell_in.den});
		rem_next = ge ? diff[OPERAND_WIDTH-1:0] : trial[OPERAND_WIDTH-1:0];
	end

	// Advance the partial remainder and quotient to the next cell
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cell_q.valid <= 1'b0;
		end else if (en) begin
			cell_q.valid <= cell_in.valid;
			cell_q.neg   <= cell_in.neg;
			cell_q.dz    <= cell_in.dz;
			cell_q.den   <= cell_in.den;
			cell_q.rem   <= rem_next;
			cell_q.dq    <= {cell_in.dq[PROD_W-2:0], ge};
		end
	end

	assign cell_out = cell_q;

endmodule

`default_nettype wire

// ----- rtl/smd_back.sv -----
// Back end: sign, wrap and overflow of the quotient, then output register and skid.
`default_nettype none

module smd_back (
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	input  wire smd_pkg::cell_t              cell_in,
	output logic                             en,
	output logic                             out_valid,
	input  wire logic                        out_ready,
	output smd_pkg::res_t                    out_res
);
	import smd_pkg::*;

	logic [OPERAND_WIDTH-1:0]        qw;
	logic signed [OPERAND_WIDTH-1:0] qs;
	logic                            ovf;
	res_t                            res;
	res_t                            res_s3, out_q, skid_q;
	logic                            valid_s3, out_valid_q, skid_valid_q;

	// Apply the sign to the low bits and check the range
	always_comb begin
		qw  = cell_in.neg ? (~cell_in.dq[OPERAND_WIDTH-1:0] + 1'b1)
		                  : cell_in.dq[OPERAND_WIDTH-1:0];
		qs  = signed'(qw);
		ovf = cell_in.dq > (LIM_POS + PROD_W'(cell_in.neg));
		res.quotient       = cell_in.dz ? '0 : FIELD_W'(qs);
		res.divide_by_zero = cell_in.dz;
		res.overflow       = cell_in.dz ? 1'b0 : ovf;
	end

	// The pipeline moves whenever the skid stage is free
	assign en = !skid_valid_q;

	// Result stage, output register and skid stage
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s3     <= 1'b0;
			out_valid_q  <= 1'b0;
			skid_valid_q <= 1'b0;
		end else begin
			if (en) begin
				valid_s3 <= cell_in.valid;
				res_s3   <= res;
			end
			if (!out_valid_q || out_ready) begin
				if (skid_valid_q) begin
					out_q        <= skid_q;
					out_valid_q  <= 1'b1;
					skid_valid_q <= 1'b0;
				end else begin
					out_q       <= res_s3;
					out_valid_q <= valid_s3;
				end
			end else if (en && valid_s3) begin
				skid_q       <= res_s3;
				skid_valid_q <= 1'b1;
			end
		end
	end

	assign out_valid = out_valid_q;
	assign out_res   = out_q;

endmodule

`default_nettype wire

// ----- tb/sv/tb_top.sv -----
// Self-checking bench for signed_mul_div_64: queued operand sets in, predicted quotients checked out.
`default_nettype none

module tb_top;

	localparam int          W           = smd_pkg::OPERAND_WIDTH;
	localparam int          LATENCY     = 2 * W + 4;
	localparam int          RANDOM_SETS = 1350;
	localparam int unsigned CYCLE_LIMIT = 400000;
	localparam logic [63:0] W_MASK      = (64'd1 << W) - 64'd1;
	localparam logic [63:0] W_SIGN      = 64'd1 << (W - 1);
	localparam logic [31:0] S32_MAX     = 32'h7FFF_FFFF;
	localparam logic [31:0] S32_MIN     = 32'h8000_0000;

	logic        clk           = 1'b0;
	logic        arst_n        = 1'b0;
	logic        s_axis_tvalid = 1'b0;
	logic        s_axis_tready;
	logic [95:0] s_axis_tdata  = '0;  // multiplicand[31:0], multiplier[63:32], divisor[95:64]
	logic        m_axis_tvalid;
	logic        m_axis_tready = 1'b0;
	logic [31:0] m_axis_tdata;        // quotient[31:0]
	logic [1:0]  m_axis_tuser;        // divide_by_zero[0], overflow[1]

	logic [95:0]   pending_operands[$];
	smd_pkg::res_t quotients_due[$];
	int unsigned   operands_total  = 0;
	int unsigned   operands_sent   = 0;
	int unsigned   results_seen    = 0;
	int unsigned   mismatches      = 0;
	int unsigned   cycles          = 0;
	int unsigned   send_idle       = 0;
	int unsigned   recv_stall      = 0;
	bit            calm            = 1'b0;

	signed_mul_div_64 dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tuser  (m_axis_tuser)
	);

	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	// Magnitude of the low W bits taken as two's complement
	function automatic logic [63:0] magnitude_of(logic [31:0] raw, output bit neg);
		logic [63:0] v;
		v   = {32'd0, raw} & W_MASK;
		neg = (v & W_SIGN) != 64'd0;
		if (neg) begin
			v = (~v + 64'd1) & W_MASK;
			if (v == 64'd0)
				v = W_SIGN;
		end
		return v;
	endfunction

	// Signed (a * b) / c, truncated, wrapped to W bits and sign-extended
	function automatic smd_pkg::res_t predict_quotient(logic [95:0] operands);
		smd_pkg::res_t r;
		bit            na, nb, nc, negative;
		logic [63:0]   ma, mb, mc, q, limit, wrapped;
		ma       = magnitude_of(operands[31:0], na);
		mb       = magnitude_of(operands[63:32], nb);
		mc       = magnitude_of(operands[95:64], nc);
		negative = na ^ nb ^ nc;
		r        = '0;
		if (mc == 64'd0) begin
			r.divide_by_zero = 1'b1;
			return r;
		end
		q       = (ma * mb) / mc;
		limit   = negative ? W_SIGN : (W_SIGN - 64'd1);
		wrapped = (negative ? (~q + 64'd1) : q) & W_MASK;
		if ((wrapped & W_SIGN) != 64'd0)
			wrapped = wrapped | ~W_MASK;
		r.quotient = wrapped[31:0];
		r.overflow = q > limit;
		return r;
	endfunction

	// Gap length: mostly none, some short, a few long; none while calm
	function automatic int unsigned pick_gap();
		int unsigned r;
		r = $urandom_range(0, 99);
		if (calm || r < 65)
			return 0;
		if (r < 92)
			return $urandom_range(1, 3);
		return $urandom_range(8, 40);
	endfunction

	function automatic logic [31:0] pick_extreme();
		case ($urandom_range(0, 6))
			0: return 32'd0;
			1: return 32'd1;
			2: return 32'hFFFF_FFFF;
			3: return S32_MAX;
			4: return S32_MIN;
			5: return S32_MAX - 32'd1;
			default: return S32_MIN + 32'd1;
		endcase
	endfunction

	function automatic logic [31:0] random_sign(logic [31:0] v);
		return $urandom_range(0, 1) ? -v : v;
	endfunction

	task automatic queue_operands(logic [31:0] a, logic [31:0] b, logic [31:0] c);
		pending_operands.push_back({c, b, a});
		operands_total++;
	endtask

	task automatic report_mismatch(string msg);
		$display("[%0d] result %0d: %s", cycles, results_seen, msg);
		mismatches++;
	endtask

	// Driver: present queued operand sets, predict each one on its transfer
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s_axis_tvalid <= 1'b0;
			s_axis_tdata  <= '0;
			send_idle     <= 0;
		end else begin
			if (s_axis_tvalid && s_axis_tready) begin
				quotients_due.push_back(predict_quotient(s_axis_tdata));
				operands_sent++;
				if (operands_sent % 128 == 0)
					calm <= ($urandom_range(0, 3) == 0);
			end
			if (!s_axis_tvalid || s_axis_tready) begin
				if (send_idle > 0) begin
					send_idle     <= send_idle - 1;
					s_axis_tvalid <= 1'b0;
				end else if (pending_operands.size() > 0) begin
					s_axis_tdata  <= pending_operands.pop_front();
					s_axis_tvalid <= 1'b1;
					send_idle     <= pick_gap();
				end else begin
					s_axis_tvalid <= 1'b0;
				end
			end
		end
	end

	// Monitor: stall at random, compare each transfer with the oldest prediction
	always @(posedge clk or negedge arst_n) begin
		smd_pkg::res_t want;
		if (!arst_n) begin
			m_axis_tready <= 1'b0;
			recv_stall    <= 0;
		end else begin
			if (m_axis_tvalid && m_axis_tready) begin
				if (quotients_due.size() == 0) begin
					report_mismatch($sformatf("unexpected result q=%h flags=%b",
						m_axis_tdata, m_axis_tuser));
				end else begin
					want = quotients_due.pop_front();
					if (m_axis_tdata !== want.quotient)
						report_mismatch($sformatf("quotient got %h want %h",
							m_axis_tdata, want.quotient));
					if (m_axis_tuser[0] !== want.divide_by_zero)
						report_mismatch($sformatf("divide_by_zero got %b want %b",
							m_axis_tuser[0], want.divide_by_zero));
					if (m_axis_tuser[1] !== want.overflow)
						report_mismatch($sformatf("overflow got %b want %b",
							m_axis_tuser[1], want.overflow));
				end
				results_seen++;
			end
			if (recv_stall > 0) begin
				recv_stall    <= recv_stall - 1;
				m_axis_tready <= 1'b0;
			end else begin
				m_axis_tready <= 1'b1;
				recv_stall    <= pick_gap();
			end
		end
	end

	// Abort a hung run
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles >= CYCLE_LIMIT) begin
			$display("FAILURE");
			$finish;
		end
	end

	// Stimulus and end of run
	initial begin
		logic [31:0] a, b, c;

		// Extremes, signs, zero divisor, wrap-around and zero quotient with negative sign
		queue_operands(32'd0, 32'd0, 32'd1);
		queue_operands(32'd0, 32'd0, 32'd0);
		queue_operands(32'd7, 32'd6, 32'd0);
		queue_operands(S32_MIN, S32_MIN, 32'd0);
		queue_operands(32'd6, 32'd7, 32'd3);
		queue_operands(-32'd6, 32'd7, 32'd4);
		queue_operands(32'd6, -32'd7, -32'd4);
		queue_operands(-32'd6, -32'd7, -32'd4);
		queue_operands(-32'd1, 32'd1, 32'd2);
		queue_operands(32'd1, 32'd1, -32'd3);
		queue_operands(S32_MIN, -32'd1, 32'd1);
		queue_operands(S32_MIN, -32'd1, -32'd1);
		queue_operands(S32_MIN, 32'd1, 32'd1);
		queue_operands(S32_MAX, S32_MAX, 32'd1);
		queue_operands(S32_MAX, S32_MAX, S32_MAX);
		queue_operands(S32_MIN, S32_MIN, S32_MIN);
		queue_operands(S32_MIN, S32_MIN, 32'd1);
		queue_operands(S32_MIN, S32_MIN, S32_MAX);
		queue_operands(S32_MAX, S32_MIN, S32_MIN);
		queue_operands(S32_MAX, S32_MAX, S32_MIN);
		queue_operands(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
		queue_operands(32'h0001_0000, 32'h0000_8000, 32'd1);
		queue_operands(32'h0001_0000, 32'h0000_8000, -32'd1);

		// Random operand sets of several shapes
		repeat (RANDOM_SETS) begin
			case ($urandom_range(0, 9))
				3: begin
					a = random_sign($urandom_range(0, 1000));
					b = random_sign($urandom_range(0, 1000));
					c = random_sign($urandom_range(1, 100));
				end
				4: begin
					a = $urandom;
					b = $urandom;
					c = random_sign($urandom | 32'h4000_0000);
				end
				5: begin
					a = $urandom;
					b = $urandom;
					c = 32'd0;
				end
				6: begin
					a = pick_extreme();
					b = pick_extreme();
					c = pick_extreme();
				end
				7: begin
					a = $urandom;
					b = $urandom;
					c = random_sign(b);
				end
				8: begin
					a = $urandom;
					b = $urandom;
					c = random_sign($urandom_range(1, 32'hFFFF));
				end
				default: begin
					a = $urandom;
					b = $urandom;
					c = $urandom;
				end
			endcase
			queue_operands(a, b, c);
		end

		// Release reset clear of the clock edge
		repeat (10) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// Drain: every set sent, every result seen, then let the pipeline empty
		while (operands_sent != operands_total || quotients_due.size() != 0)
			@(posedge clk);
		repeat (LATENCY + 32) @(posedge clk);

		if (mismatches == 0 && quotients_due.size() == 0) begin
			$display("SUCCESS");
		end else begin
			$display("FAILURE");
		end
		$finish;
	end

endmodule

`default_nettype wire

// ----- signed_mul_div_64.f -----
rtl/smd_pkg.sv
rtl/smd_front.sv
rtl/smd_div_cell.sv
rtl/smd_back.sv
rtl/signed_mul_div_64.sv
tb/sv/tb_top.sv
